[hdl/mcmp_pkg.sv]
`timescale 1ns / 1ps

package mcmp_pkg;

  // Upper nibbles of status bytes
  localparam logic [3:0] ST_NOTE_OFF      = 4'h8;
  localparam logic [3:0] ST_NOTE_ON       = 4'h9;
  localparam logic [3:0] ST_PITCH_BEND    = 4'hE;
  localparam logic [3:0] ST_PROG_CHANGE   = 4'hC;
  localparam logic [3:0] ST_CHAN_PRESSURE = 4'hD;
  localparam logic [3:0] ST_SYSTEM        = 4'hF;

  // One completed channel message
  typedef struct packed {
    logic [3:0] msg_status;
    logic [3:0] msg_channel;
    logic [6:0] first_data;
    logic [6:0] second_data;
    logic [1:0] data_count;
    logic       is_note;
    logic [6:0] note_velocity;
  } msg_t;

  // Data bytes a channel status expects; 0 for anything else
  function automatic logic [1:0] msg_length(input logic [3:0] st);
    logic [1:0] len;
    case (st) inside
      ST_PROG_CHANGE, ST_CHAN_PRESSURE: len = 2'd1;
      [ST_NOTE_OFF:ST_PITCH_BEND]:      len = 2'd2;
      default:                          len = 2'd0;
    endcase
    return len;
  endfunction

endpackage

[hdl/midi_channel_message_parser_top.sv]
`timescale 1ns / 1ps

// MIDI channel message parser with running status.
// Input channel: one received MIDI byte per transaction (in_valid/in_ready,
// in_byte). Bit 7 set marks a status byte; channel status bytes open a
// message, system bytes (0xF0-0xFF) and any status byte drop a partial one.
// Data bytes with nothing pending reuse the last completed status, channel
// and length; before any message has completed they are discarded.
// Result channel: one transaction per completed message (out_valid/out_ready)
// carrying status, channel, both data bytes, count, note flag and velocity.
// The completing byte's result is registered in the output register, or in
// the skid when the output stalls. Throughput: one byte per cycle while in_ready is high.
// The parser state updates in the accepting cycle; results go to an output
// register backed by a one-entry skid register, so the input side keeps
// taking bytes while a result waits. in_ready drops only when both are full.
// Reset (rst_n low, synchronous): no message pending, no running status,
// both result registers empty.
module midi_channel_message_parser_top (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [3:0] out_msg_status,
  output logic [3:0] out_msg_channel,
  output logic [6:0] out_first_data,
  output logic [6:0] out_second_data,
  output logic [1:0] out_data_count,
  output logic       out_is_note,
  output logic [6:0] out_note_velocity
);

  // Message being assembled
  logic [3:0] cur_status_r, cur_status_nxt;
  logic [3:0] cur_channel_r, cur_channel_nxt;
  logic [6:0] cur_first_r, cur_first_nxt;
  logic [1:0] cur_pending_r, cur_pending_nxt;
  logic [1:0] cur_received_r, cur_received_nxt;
  // Running status
  logic [3:0] run_status_r, run_status_nxt;
  logic [3:0] run_channel_r, run_channel_nxt;
  logic [1:0] run_length_r, run_length_nxt;

  // Result buffering: output register plus skid
  mcmp_pkg::msg_t out_r, skid_r, res;
  logic           out_vld_r, skid_vld_r;
  logic           res_vld;

  logic       accept;
  logic       pop;
  logic       push;
  logic [6:0] din;

  // Scratch for the data byte path
  logic [3:0] st, ch;
  logic [6:0] fd;
  logic [1:0] pend, rcv;
  logic [6:0] second;

  assign in_ready = !skid_vld_r;
  assign accept   = in_valid && in_ready;
  assign pop      = out_vld_r && out_ready;
  assign push     = accept && res_vld;
  assign din      = in_byte[6:0];

  always_comb begin
    cur_status_nxt   = cur_status_r;
    cur_channel_nxt  = cur_channel_r;
    cur_first_nxt    = cur_first_r;
    cur_pending_nxt  = cur_pending_r;
    cur_received_nxt = cur_received_r;
    run_status_nxt   = run_status_r;
    run_channel_nxt  = run_channel_r;
    run_length_nxt   = run_length_r;
    res_vld          = 1'b0;
    res              = '0;
    st               = cur_status_r;
    ch               = cur_channel_r;
    fd               = cur_first_r;
    pend             = cur_pending_r;
    rcv              = cur_received_r;
    second           = '0;

    if (in_byte[7]) begin
      // any status byte drops the partial message
      cur_status_nxt   = '0;
      cur_channel_nxt  = '0;
      cur_first_nxt    = '0;
      cur_pending_nxt  = '0;
      cur_received_nxt = '0;
      if (in_byte[7:4] != mcmp_pkg::ST_SYSTEM) begin
        cur_status_nxt  = in_byte[7:4];
        cur_channel_nxt = in_byte[3:0];
        cur_pending_nxt = mcmp_pkg::msg_length(in_byte[7:4]);
      end
    end else begin
      // idle: reopen from running status
      if (cur_pending_r == 2'd0) begin
        st   = run_status_r;
        ch   = run_channel_r;
        pend = run_length_r;
        rcv  = '0;
        fd   = '0;
      end
      if (pend != 2'd0) begin
        pend = pend - 2'd1;
        if (rcv == 2'd0) begin
          fd = din;
        end
        rcv = rcv + 2'd1;
      end
      cur_status_nxt   = st;
      cur_channel_nxt  = ch;
      cur_first_nxt    = fd;
      cur_pending_nxt  = pend;
      cur_received_nxt = rcv;
      if (pend == 2'd0 && rcv != 2'd0) begin
        // message complete
        second            = (rcv == 2'd2) ? din : 7'd0;
        res_vld           = 1'b1;
        res.msg_status    = st;
        res.msg_channel   = ch;
        res.first_data    = fd;
        res.second_data   = second;
        res.data_count    = rcv;
        res.is_note       = (st == mcmp_pkg::ST_NOTE_OFF) || (st == mcmp_pkg::ST_NOTE_ON);
        res.note_velocity = (st == mcmp_pkg::ST_NOTE_ON) ? second : 7'd0;
        run_status_nxt    = st;
        run_channel_nxt   = ch;
        run_length_nxt    = rcv;
        cur_status_nxt    = '0;
        cur_channel_nxt   = '0;
        cur_first_nxt     = '0;
        cur_pending_nxt   = '0;
        cur_received_nxt  = '0;
      end
    end
  end

  // Parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_status_r   <= '0;
      cur_channel_r  <= '0;
      cur_first_r    <= '0;
      cur_pending_r  <= '0;
      cur_received_r <= '0;
      run_status_r   <= '0;
      run_channel_r  <= '0;
      run_length_r   <= '0;
    end else if (accept) begin
      cur_status_r   <= cur_status_nxt;
      cur_channel_r  <= cur_channel_nxt;
      cur_first_r    <= cur_first_nxt;
      cur_pending_r  <= cur_pending_nxt;
      cur_received_r <= cur_received_nxt;
      run_status_r   <= run_status_nxt;
      run_channel_r  <= run_channel_nxt;
      run_length_r   <= run_length_nxt;
    end
  end

  // Result register and skid: skid holds a result only while the output
  // register is full and stalled; it drains into the output register first.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (skid_vld_r) begin
      if (pop) begin
        skid_vld_r <= 1'b0;
      end
    end else if (push) begin
      if (!out_vld_r || pop) begin
        out_vld_r <= 1'b1;
      end else begin
        skid_vld_r <= 1'b1;
      end
    end else if (pop) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_vld_r) begin
      if (pop) begin
        out_r <= skid_r;
      end
    end else if (push) begin
      if (!out_vld_r || pop) begin
        out_r <= res;
      end else begin
        skid_r <= res;
      end
    end
  end

  assign out_valid         = out_vld_r;
  assign out_msg_status    = out_r.msg_status;
  assign out_msg_channel   = out_r.msg_channel;
  assign out_first_data    = out_r.first_data;
  assign out_second_data   = out_r.second_data;
  assign out_data_count    = out_r.data_count;
  assign out_is_note       = out_r.is_note;
  assign out_note_velocity = out_r.note_velocity;

  // Skid is only used behind a full output register
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_vld_r |-> out_vld_r)
    else $error("skid register full while output register empty");

  // A message never waits on more than two data bytes
  a_pending_range: assert property (@(posedge clk) disable iff (!rst_n)
    cur_pending_r != 2'd3)
    else $error("pending count out of range");

  // One-byte messages carry no second byte and no velocity
  a_short_msg: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_r.data_count == 2'd1) |->
      (out_r.second_data == 7'd0 && out_r.note_velocity == 7'd0))
    else $error("one-byte message with nonzero second data");

endmodule
